// File: rtl/emrs_pkg.sv
// Shared constants, codes and types for the extent map request splitter.
// No dependencies; every other file of the block imports this package.
package emrs_pkg;

    // Table and result limits.
    localparam int MAX_EXTENTS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
    localparam int K_W         = $clog2(MAX_RESULTS);

    // Command queue between front and back; depth must be a power of two, at least 2.
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // Field widths.
    localparam int LBA_W       = 64;
    localparam int SEC_W       = 32;
    localparam int ENTRY_IDX_W = 4;
    localparam int COUNT_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int KIND_W      = 2;

    // Command kinds decided by the front.
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_XFER  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WR_DENIED = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WREN  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [ENTRY_IDX_W-1:0] idx;
        logic [LBA_W-1:0]       ent_start;
        logic [LBA_W-1:0]       ent_len;
        logic [LBA_W-1:0]       start_sector;
        logic [SEC_W-1:0]       total;
        logic                   wr;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// File: rtl/emrs_front.sv
// Front end: takes an item from the command port and classifies it into a queue command.
// Depends on emrs_pkg.
module emrs_front
    import emrs_pkg::*;
(
    input  logic                   i_start,
    input  logic                   i_full,
    input  logic                   i_action,
    input  logic [ENTRY_IDX_W-1:0] i_entry_index,
    input  logic [LBA_W-1:0]       i_entry_start,
    input  logic [LBA_W-1:0]       i_entry_length,
    input  logic [LBA_W-1:0]       i_start_sector,
    input  logic [SEC_W-1:0]       i_sector_total,
    input  logic                   i_is_write,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    always_comb begin
        o_push             = i_start && !i_full;
        o_cmd.idx          = i_entry_index;
        o_cmd.ent_start    = i_entry_start;
        o_cmd.ent_len      = i_entry_length;
        o_cmd.start_sector = i_start_sector;
        o_cmd.total        = i_sector_total;
        o_cmd.wr           = i_is_write;
        if (!i_action) begin
            o_cmd.kind = KIND_LOAD;
        end else if (i_sector_total == '0) begin
            // An empty request is answered at once without a table walk.
            o_cmd.kind = KIND_EMPTY;
        end else begin
            o_cmd.kind = KIND_XFER;
        end
    end

endmodule

// File: rtl/emrs_cmd_fifo.sv
// Short command queue that decouples the front end from the back end.
// Depends on emrs_pkg.
module emrs_cmd_fifo
    import emrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd       i_cmd,
    input  logic       i_pop,
    output t_cmd       o_head,
    output t_fifo_stat o_stat
);

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr, n_wptr;
    logic [FIFO_PTR_W-1:0] r_rptr, n_rptr;
    logic [FIFO_CNT_W-1:0] r_cnt,  n_cnt;
    logic                  do_push, do_pop;

    always_comb begin
        o_stat.full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
        o_stat.empty = (r_cnt == '0);
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        n_wptr       = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr       = do_pop  ? r_rptr + 1'b1 : r_rptr;
        n_cnt        = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
        o_head = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/emrs_back.sv
// Back end: holds configuration and the extent table, walks the table and issues results.
// Depends on emrs_pkg.
module emrs_back
    import emrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_fifo_stat             i_fifo_stat,
    input  t_cmd                   i_head,
    output logic                   o_pop,
    output logic                   o_strobe,
    output logic [LBA_W-1:0]       o_host_sector,
    output logic [SEC_W-1:0]       o_run_length,
    output logic [SEC_W-1:0]       o_buffer_offset,
    output logic                   o_write_flag,
    output logic [STATUS_W-1:0]    o_status,
    output logic                   o_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_HIT  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_NEXT = 3'd4;

    // Configuration.
    logic [LBA_W-1:0]   r_base;
    logic [COUNT_W-1:0] r_count;
    logic               r_wren;

    // Extent table, valid only where loaded.
    logic [LBA_W-1:0] r_tab_start [MAX_EXTENTS];
    logic [LBA_W-1:0] r_tab_len   [MAX_EXTENTS];
    logic             tab_we;

    // Walk state.
    logic [2:0]       r_state, n_state;
    logic [LBA_W-1:0] r_start, n_start;
    logic [SEC_W-1:0] r_total, n_total;
    logic             r_wr,    n_wr;
    logic [SEC_W-1:0] r_done,  n_done;
    logic [K_W-1:0]   r_k,     n_k;
    logic [CNT_W-1:0] r_x,     n_x;
    logic [LBA_W-1:0] r_rem,   n_rem;
    logic [LBA_W-1:0] r_left,  n_left;
    logic [LBA_W-1:0] r_hostp, n_hostp;
    logic [SEC_W-1:0] r_want,  n_want;

    // Result register.
    logic                r_out_stb,  n_out_stb;
    logic [LBA_W-1:0]    r_out_lba,  n_out_lba;
    logic [SEC_W-1:0]    r_out_run,  n_out_run;
    logic [SEC_W-1:0]    r_out_off,  n_out_off;
    logic                r_out_wr,   n_out_wr;
    logic [STATUS_W-1:0] r_out_st,   n_out_st;
    logic                r_out_last, n_out_last;

    logic [CNT_W-1:0] used;
    logic [LBA_W-1:0] len_x;
    logic [LBA_W-1:0] start_x;
    logic             fin;
    logic [SEC_W-1:0] run_n;

    always_comb begin
        used    = (32'(r_count) < 32'(MAX_EXTENTS)) ? CNT_W'(r_count) : CNT_W'(MAX_EXTENTS);
        len_x   = r_tab_len[r_x[IDX_W-1:0]];
        start_x = r_tab_start[r_x[IDX_W-1:0]];
        fin     = ({{(LBA_W - SEC_W){1'b0}}, r_want} <= r_left);
        run_n   = fin ? r_want : r_left[SEC_W-1:0];

        n_state    = r_state;
        n_start    = r_start;
        n_total    = r_total;
        n_wr       = r_wr;
        n_done     = r_done;
        n_k        = r_k;
        n_x        = r_x;
        n_rem      = r_rem;
        n_left     = r_left;
        n_hostp    = r_hostp;
        n_want     = r_want;
        n_out_stb  = 1'b0;
        n_out_lba  = r_out_lba;
        n_out_run  = r_out_run;
        n_out_off  = r_out_off;
        n_out_wr   = r_out_wr;
        n_out_st   = r_out_st;
        n_out_last = r_out_last;
        o_pop      = 1'b0;
        tab_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_fifo_stat.empty) begin
                    o_pop = 1'b1;
                    case (i_head.kind)
                        KIND_LOAD: begin
                            tab_we = (32'(i_head.idx) < 32'(MAX_EXTENTS));
                        end
                        KIND_EMPTY: begin
                            n_out_stb  = 1'b1;
                            n_out_lba  = '0;
                            n_out_run  = '0;
                            n_out_off  = '0;
                            n_out_wr   = i_head.wr;
                            n_out_st   = ST_OK;
                            n_out_last = 1'b1;
                        end
                        KIND_XFER: begin
                            n_start = i_head.start_sector;
                            n_total = i_head.total;
                            n_wr    = i_head.wr;
                            n_done  = '0;
                            n_k     = '0;
                            n_x     = '0;
                            n_rem   = i_head.start_sector;
                            n_state = S_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_x >= used) begin
                    n_out_stb  = 1'b1;
                    n_out_lba  = '0;
                    n_out_run  = '0;
                    n_out_off  = r_done;
                    n_out_wr   = r_wr;
                    n_out_st   = ST_UNMAPPED;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end else if (r_rem < len_x) begin
                    n_state = S_HIT;
                end else begin
                    n_rem = r_rem - len_x;
                    n_x   = r_x + 1'b1;
                end
            end
            S_HIT: begin
                if (r_wr && !r_wren) begin
                    n_out_stb  = 1'b1;
                    n_out_lba  = '0;
                    n_out_run  = '0;
                    n_out_off  = r_done;
                    n_out_wr   = r_wr;
                    n_out_st   = ST_WR_DENIED;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_left  = len_x - r_rem;
                    n_hostp = r_base + start_x;
                    n_want  = r_total - r_done;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_out_stb = 1'b1;
                n_out_off = r_done;
                n_out_wr  = r_wr;
                if ((r_k == K_W'(MAX_RESULTS - 1)) && !fin) begin
                    // Result slots used up before the request is covered.
                    n_out_lba  = '0;
                    n_out_run  = '0;
                    n_out_st   = ST_UNMAPPED;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_out_lba  = r_hostp + r_rem;
                    n_out_run  = run_n;
                    n_out_st   = ST_OK;
                    n_out_last = fin;
                    n_done     = r_done + run_n;
                    n_k        = r_k + 1'b1;
                    n_state    = fin ? S_IDLE : S_NEXT;
                end
            end
            S_NEXT: begin
                n_rem   = r_start + {{(LBA_W - SEC_W){1'b0}}, r_done};
                n_x     = '0;
                n_state = S_WALK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_stb <= 1'b0;
            r_base    <= '0;
            r_count   <= '0;
            r_wren    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_stb <= n_out_stb;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE:  r_base  <= i_cfg_data;
                    CFG_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_WREN:  r_wren  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start    <= n_start;
        r_total    <= n_total;
        r_wr       <= n_wr;
        r_done     <= n_done;
        r_k        <= n_k;
        r_x        <= n_x;
        r_rem      <= n_rem;
        r_left     <= n_left;
        r_hostp    <= n_hostp;
        r_want     <= n_want;
        r_out_lba  <= n_out_lba;
        r_out_run  <= n_out_run;
        r_out_off  <= n_out_off;
        r_out_wr   <= n_out_wr;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
        if (tab_we) begin
            r_tab_start[IDX_W'(i_head.idx)] <= i_head.ent_start;
            r_tab_len[IDX_W'(i_head.idx)]   <= i_head.ent_len;
        end
    end

    assign o_strobe        = r_out_stb;
    assign o_host_sector   = r_out_lba;
    assign o_run_length    = r_out_run;
    assign o_buffer_offset = r_out_off;
    assign o_write_flag    = r_out_wr;
    assign o_status        = r_out_st;
    assign o_last          = r_out_last;

endmodule

// File: rtl/extent_map_request_splitter_core.sv
// Top level of the extent map request splitter: front end, command queue and back end.
// Depends on emrs_pkg, emrs_front, emrs_cmd_fifo and emrs_back.
//
// Usage. The block translates runs of guest sectors into host commands through a table of
// sixteen extents. An item is transferred in at a rising edge where start is high and busy
// is low; it either loads one table slot or requests a read or write transfer. Each result
// is shown for exactly one cycle with o_strobe high and is taken at the end of that cycle:
// the receiver cannot hold results off, so no result ever waits.
// Configuration (partition base, extent count, write enable) is written through i_cfg_we,
// i_cfg_idx and i_cfg_data while the block is idle; writes take effect at once.
// Timing. Items pass a two-entry command queue; busy is high only while it is full. The back
// end takes one queued item per cycle when idle. A slot load gives no result. An empty
// request gives its result through the result register once it has left the queue, with no
// table walk. A transfer leaves the queue and then, for each piece, walks the table up to
// the slot that holds the piece's first sector, then translates, issues and restarts: every
// piece walks the table from slot 0 again, one slot a cycle through the single length
// comparator.
// Reset (synchronous, active low) clears the queue, the sequencer and the configuration;
// table slots are undefined until loaded.
module extent_map_request_splitter_core
    import emrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_action,
    input  logic [ENTRY_IDX_W-1:0] i_entry_index,
    input  logic [LBA_W-1:0]       i_entry_start,
    input  logic [LBA_W-1:0]       i_entry_length,
    input  logic [LBA_W-1:0]       i_start_sector,
    input  logic [SEC_W-1:0]       i_sector_total,
    input  logic                   i_is_write,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_strobe,
    output logic [LBA_W-1:0]       o_host_sector,
    output logic [SEC_W-1:0]       o_run_length,
    output logic [SEC_W-1:0]       o_buffer_offset,
    output logic                   o_write_flag,
    output logic [STATUS_W-1:0]    o_status,
    output logic                   o_last
);

    logic       push;
    logic       pop;
    t_cmd       cmd;
    t_cmd       head;
    t_fifo_stat fifo_stat;

    // The queue being full is the only reason to refuse a transfer.
    assign busy = fifo_stat.full;

    emrs_front u_front (
        .i_start        (start),
        .i_full         (fifo_stat.full),
        .i_action       (i_action),
        .i_entry_index  (i_entry_index),
        .i_entry_start  (i_entry_start),
        .i_entry_length (i_entry_length),
        .i_start_sector (i_start_sector),
        .i_sector_total (i_sector_total),
        .i_is_write     (i_is_write),
        .o_push         (push),
        .o_cmd          (cmd)
    );

    // Slot loads travel through the queue as well, so that they stay in order with
    // transfers still being walked.
    emrs_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (fifo_stat)
    );

    emrs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_fifo_stat     (fifo_stat),
        .i_head          (head),
        .o_pop           (pop),
        .o_strobe        (o_strobe),
        .o_host_sector   (o_host_sector),
        .o_run_length    (o_run_length),
        .o_buffer_offset (o_buffer_offset),
        .o_write_flag    (o_write_flag),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule

// File: rtl/emrs_chk.sv
// Port-level checker for the extent map request splitter, bound to the top level.
// Depends on emrs_pkg and extent_map_request_splitter_core.
module emrs_chk
    import emrs_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_busy,
    input logic                i_strobe,
    input logic [LBA_W-1:0]    i_host_sector,
    input logic [SEC_W-1:0]    i_run_length,
    input logic [STATUS_W-1:0] i_status,
    input logic                i_last
);

    // Reset leaves no result pending and the queue open.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_strobe && !i_busy)
        else $error("result or busy right after reset");

    // An error result always ends its request.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe && (i_status != ST_OK) |-> i_last)
        else $error("error result without last");

    // An error result carries no host command.
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe && (i_status != ST_OK) |-> (i_host_sector == '0) && (i_run_length == '0))
        else $error("error result with address or length");

    // A piece that does not end its request is followed by a fresh table walk.
    a_piece_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe && !i_last |=> !i_strobe)
        else $error("back-to-back results inside one request");

endmodule

bind extent_map_request_splitter_core emrs_chk u_emrs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_busy        (busy),
    .i_strobe      (o_strobe),
    .i_host_sector (o_host_sector),
    .i_run_length  (o_run_length),
    .i_status      (o_status),
    .i_last        (o_last)
);

// File: verif/emrs_tb_codes_pkg.sv
// Codes shared by the extent map request splitter testbench: item actions and a spare register index.
// Depends on emrs_pkg for the configuration index width.
`timescale 1ns / 1ps

package emrs_tb_codes_pkg;
    import emrs_pkg::*;

    // Kind of input item.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_XFER = 1'b1;

    // The one configuration index that selects no register.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

endpackage

// File: verif/emrs_translation_monitor.sv
// Watches the splitter's ports, predicts the host commands of every request and checks each result.
// Depends on emrs_pkg and emrs_tb_codes_pkg; hands counts back to the testbench top.
`timescale 1ns / 1ps

module emrs_translation_monitor
    import emrs_pkg::*;
    import emrs_tb_codes_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic                   i_action,
    input  logic [ENTRY_IDX_W-1:0] i_entry_index,
    input  logic [LBA_W-1:0]       i_entry_start,
    input  logic [LBA_W-1:0]       i_entry_length,
    input  logic [LBA_W-1:0]       i_start_sector,
    input  logic [SEC_W-1:0]       i_sector_total,
    input  logic                   i_is_write,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   o_strobe,
    input  logic [LBA_W-1:0]       o_host_sector,
    input  logic [SEC_W-1:0]       o_run_length,
    input  logic [SEC_W-1:0]       o_buffer_offset,
    input  logic                   o_write_flag,
    input  logic [STATUS_W-1:0]    o_status,
    input  logic                   o_last,
    output int                     o_pending,
    output int                     o_fail_count,
    output int                     o_results_seen
);

    typedef struct packed {
        logic [LBA_W-1:0]    host_sector;
        logic [SEC_W-1:0]    run_length;
        logic [SEC_W-1:0]    buffer_offset;
        logic                write_flag;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_piece;

    t_piece           expected_pieces[$];
    logic [LBA_W-1:0] extent_start_copy[MAX_EXTENTS];
    logic [LBA_W-1:0] extent_len_copy[MAX_EXTENTS];
    logic [LBA_W-1:0] base_reg;
    logic [COUNT_W-1:0] count_reg;
    logic             wren_reg;

    function automatic t_piece piece_of(input logic [LBA_W-1:0] lba, input logic [SEC_W-1:0] run,
                                        input logic [SEC_W-1:0] off, input logic wr,
                                        input logic [STATUS_W-1:0] st, input logic fin);
        t_piece p;
        p.host_sector   = lba;
        p.run_length    = run;
        p.buffer_offset = off;
        p.write_flag    = wr;
        p.status        = st;
        p.last          = fin;
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    // Splits one request into host commands, walking the table from slot 0 for every piece.
    task automatic translate_request(input logic [LBA_W-1:0] first_sector,
                                     input logic [SEC_W-1:0] total, input logic wr);
        logic [SEC_W-1:0] covered;
        logic [SEC_W-1:0] want;
        logic [SEC_W-1:0] run;
        logic [LBA_W-1:0] rem;
        logic [LBA_W-1:0] host;
        logic [LBA_W-1:0] left;
        int               pieces;
        int               used;
        int               x;
        logic             found;
        logic             done;
        covered = '0;
        pieces  = 0;
        done    = 1'b0;
        host    = '0;
        left    = '0;
        used    = (count_reg > MAX_EXTENTS) ? MAX_EXTENTS : int'(count_reg);
        if (total == '0) begin
            expected_pieces.push_back(piece_of('0, '0, '0, wr, ST_OK, 1'b1));
            done = 1'b1;
        end
        while (!done && covered < total) begin
            want  = total - covered;
            rem   = first_sector + {{(LBA_W-SEC_W){1'b0}}, covered};
            found = 1'b0;
            for (x = 0; x < used && !found; x++) begin
                if (rem < extent_len_copy[x]) begin
                    found = 1'b1;
                    host  = base_reg + extent_start_copy[x] + rem;
                    left  = extent_len_copy[x] - rem;
                end else begin
                    rem = rem - extent_len_copy[x];
                end
            end
            if (!found) begin
                expected_pieces.push_back(piece_of('0, '0, covered, wr, ST_UNMAPPED, 1'b1));
                done = 1'b1;
            end else if (wr && !wren_reg) begin
                expected_pieces.push_back(piece_of('0, '0, covered, wr, ST_WR_DENIED, 1'b1));
                done = 1'b1;
            end else begin
                run = ({{(LBA_W-SEC_W){1'b0}}, want} < left) ? want : left[SEC_W-1:0];
                if (pieces == MAX_RESULTS - 1 && run != want) begin
                    // Out of result slots: the last one reports the request as unfinished.
                    expected_pieces.push_back(piece_of('0, '0, covered, wr, ST_UNMAPPED, 1'b1));
                    done = 1'b1;
                end else begin
                    expected_pieces.push_back(piece_of(host, run, covered, wr, ST_OK, run == want));
                    covered = covered + run;
                    pieces++;
                end
            end
        end
    endtask

    task automatic check_result();
        t_piece got;
        t_piece want;
        got = piece_of(o_host_sector, o_run_length, o_buffer_offset, o_write_flag, o_status,
                       o_last);
        o_results_seen++;
        if (expected_pieces.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none outstanding (lba %h status %0d)",
                                      o_results_seen, got.host_sector, got.status));
        end else begin
            want = expected_pieces.pop_front();
            if (got.host_sector !== want.host_sector)
                report_mismatch($sformatf("result %0d host_sector %h, predicted %h",
                                          o_results_seen, got.host_sector, want.host_sector));
            if (got.run_length !== want.run_length)
                report_mismatch($sformatf("result %0d run_length %0d, predicted %0d",
                                          o_results_seen, got.run_length, want.run_length));
            if (got.buffer_offset !== want.buffer_offset)
                report_mismatch($sformatf("result %0d buffer_offset %0d, predicted %0d",
                                          o_results_seen, got.buffer_offset, want.buffer_offset));
            if (got.write_flag !== want.write_flag)
                report_mismatch($sformatf("result %0d write_flag %b, predicted %b",
                                          o_results_seen, got.write_flag, want.write_flag));
            if (got.status !== want.status)
                report_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                          o_results_seen, got.status, want.status));
            if (got.last !== want.last)
                report_mismatch($sformatf("result %0d last %b, predicted %b",
                                          o_results_seen, got.last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_pieces.delete();
            base_reg  = '0;
            count_reg = '0;
            wren_reg  = 1'b0;
        end else begin
            // Results first: one arriving now always belongs to an earlier request.
            if (o_strobe) begin
                check_result();
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE:  base_reg  = i_cfg_data;
                    CFG_COUNT: count_reg = i_cfg_data[COUNT_W-1:0];
                    CFG_WREN:  wren_reg  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (i_action == ACT_LOAD) begin
                    extent_start_copy[i_entry_index] = i_entry_start;
                    extent_len_copy[i_entry_index]   = i_entry_length;
                end else begin
                    translate_request(i_start_sector, i_sector_total, i_is_write);
                end
            end
        end
        o_pending = expected_pieces.size();
    end

endmodule

// File: verif/tb.sv
// Testbench top for the extent map request splitter: clock, reset, stimulus and the verdict.
// Depends on emrs_pkg, emrs_tb_codes_pkg, emrs_translation_monitor and the splitter core.
`timescale 1ns / 1ps

module tb;
    import emrs_pkg::*;
    import emrs_tb_codes_pkg::*;

    // The slowest request walks up to sixteen slots for each of sixteen pieces, plus the
    // steps per piece that translate and issue it; a little margin covers the queue stages.
    localparam int DRAIN_CYCLES = MAX_RESULTS * (MAX_EXTENTS + 3) + 8;
    // A fixed bound far beyond the slowest correct run, which is a few milliseconds.
    localparam int WATCHDOG_NS  = 20_000_000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_action;
    logic [ENTRY_IDX_W-1:0] i_entry_index;
    logic [LBA_W-1:0]       i_entry_start;
    logic [LBA_W-1:0]       i_entry_length;
    logic [LBA_W-1:0]       i_start_sector;
    logic [SEC_W-1:0]       i_sector_total;
    logic                   i_is_write;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   o_strobe;
    logic [LBA_W-1:0]       o_host_sector;
    logic [SEC_W-1:0]       o_run_length;
    logic [SEC_W-1:0]       o_buffer_offset;
    logic                   o_write_flag;
    logic [STATUS_W-1:0]    o_status;
    logic                   o_last;

    // Counts handed back by the monitor.
    int o_pending;
    int o_fail_count;
    int o_results_seen;

    // Stimulus bookkeeping for the closing summary.
    int idle_pct;
    int loads_sent;
    int transfers_sent;
    int settings_used;

    always #10 i_clk = ~i_clk;

    extent_map_request_splitter_core dut (.*);

    emrs_translation_monitor monitor (.*);

    // Watchdog: a hung handshake or a result that never arrives ends the run here.
    initial begin
        #(WATCHDOG_NS);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Presents one item and holds it until the block takes it. Before raising start the sender
    // may idle for a random number of cycles; start is only lowered while idling, so an item
    // that follows directly keeps start high without a glitch in the same time step. The task
    // returns just after the edge at which the transfer happened.
    task automatic send_item(input logic action, input logic [ENTRY_IDX_W-1:0] idx,
                             input logic [LBA_W-1:0] ent_start, input logic [LBA_W-1:0] ent_len,
                             input logic [LBA_W-1:0] sector, input logic [SEC_W-1:0] total,
                             input logic wr);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= action;
        i_entry_index  <= idx;
        i_entry_start  <= ent_start;
        i_entry_length <= ent_len;
        i_start_sector <= sector;
        i_sector_total <= total;
        i_is_write     <= wr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (action == ACT_LOAD) loads_sent++;
        else transfers_sent++;
    endtask

    // The fields that an item does not use are filled with noise; the block must ignore them.
    task automatic send_load(input logic [ENTRY_IDX_W-1:0] idx, input logic [LBA_W-1:0] ent_start,
                             input logic [LBA_W-1:0] ent_len);
        send_item(ACT_LOAD, idx, ent_start, ent_len, rand64(), $urandom,
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_transfer(input logic [LBA_W-1:0] sector, input logic [SEC_W-1:0] total,
                                 input logic wr);
        send_item(ACT_XFER, ENTRY_IDX_W'($urandom_range(0, 15)), rand64(), rand64(), sector,
                  total, wr);
    endtask

    // Waits until every predicted result has come back, then lets the block finish any slot
    // loads still in its queue, which produce no result and so cannot be observed. The pending
    // count is read on the falling edge, well clear of the monitor's update.
    task automatic settle();
        start <= 1'b0;
        @(negedge i_clk);
        while (o_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three registers and then the spare index, which must change nothing. The
    // count and enable registers get random upper bits, which the block has to ignore.
    task automatic configure(input logic [LBA_W-1:0] base, input logic [COUNT_W-1:0] count,
                             input logic wren);
        logic [CFG_DATA_W-1:0] noise;
        noise      = rand64();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BASE;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_COUNT;
        i_cfg_data <= {noise[CFG_DATA_W-1:COUNT_W], count};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_WREN;
        i_cfg_data <= {noise[CFG_DATA_W-1:1], wren};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= rand64();
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // Random traffic. Most requests start inside the mapped range and are short compared with
    // the table, so that they split into several pieces; a few use full-width values to reach
    // the unmapped and overlong cases and to exercise every bit of the fields. Most extents
    // are short, an occasional one is enormous, and zero-length ones appear now and then.
    task automatic send_random_item();
        logic [LBA_W-1:0] len;
        logic [LBA_W-1:0] sector;
        logic [SEC_W-1:0] total;
        int               pick;
        if ($urandom_range(0, 99) < 20) begin
            len = ($urandom_range(0, 99) < 8) ? rand64() : {32'b0, $urandom_range(0, 24)};
            send_load(ENTRY_IDX_W'($urandom_range(0, 15)), rand64(), len);
        end else begin
            sector = ($urandom_range(0, 99) < 8) ? rand64() : {32'b0, $urandom_range(0, 220)};
            pick   = $urandom_range(0, 99);
            if (pick < 5) total = $urandom;
            else if (pick < 10) total = '0;
            else total = $urandom_range(1, 48);
            send_transfer(sector, total, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int ph;
        int blk;
        int n;
        logic [LBA_W-1:0] base;
        logic [COUNT_W-1:0] count;

        // Every input known from time zero; reset held low at the start.
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_action       <= ACT_LOAD;
        i_entry_index  <= '0;
        i_entry_start  <= '0;
        i_entry_length <= '0;
        i_start_sector <= '0;
        i_sector_total <= '0;
        i_is_write     <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_BASE;
        i_cfg_data     <= '0;
        idle_pct       = 13;
        loads_sent     = 0;
        transfers_sent = 0;
        settings_used  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight out of reset no extent is in use: any request is unmapped, while an empty
        // request still gives its single empty result, even as a write.
        send_transfer(64'd0, 32'd5, 1'b0);
        send_transfer(64'd0, 32'd0, 1'b1);

        // Fill the whole table before any request can reach it. Slot i holds i + 1 sectors,
        // except slot 5 which is empty and must be skipped; the last slot starts at the top of
        // the host range so that its addresses wrap.
        for (n = 0; n < MAX_EXTENTS; n++) begin
            send_load(ENTRY_IDX_W'(n), (n == MAX_EXTENTS - 1) ? '1 : LBA_W'(n) * 64'd1000,
                      (n == 5) ? 64'd0 : LBA_W'(n + 1));
        end

        // High base, all sixteen slots in use, writes refused. The fifteen non-empty
        // extents map guest sectors 0 to 129.
        settle();
        configure(64'hFFFF_FFFF_FFFF_FFF0, COUNT_W'(MAX_EXTENTS), 1'b0);
        send_transfer(64'd0, 32'd130, 1'b0);      // the whole table, host address wrapping
        send_transfer(64'd0, 32'd131, 1'b0);      // runs one sector past the mapped range
        send_transfer(64'd129, 32'd1, 1'b0);      // the very last mapped sector
        send_transfer(64'd130, 32'd1, 1'b0);      // the first unmapped sector
        send_transfer('1, 32'd1, 1'b0);           // highest guest sector
        send_transfer(64'd3, 32'd4, 1'b1);        // write while writes are disabled
        send_transfer(64'd500, 32'd4, 1'b1);      // unmapped write: unmapped takes priority
        send_transfer(64'd7, '1, 1'b0);           // largest request
        // Giving slot 5 one sector makes sixteen non-empty extents, so a request that runs
        // past the end uses up every result slot without finishing.
        send_load(4'd5, 64'h8000_0000_0000_0000, 64'd1);
        send_transfer(64'd0, 32'd132, 1'b0);
        send_transfer(64'd0, 32'd131, 1'b0);      // exactly sixteen pieces
        send_transfer(64'd40, 32'd0, 1'b0);       // empty read

        // Zero base, the count above the table size (clamped), writes allowed.
        settle();
        configure('0, '1, 1'b1);
        send_transfer(64'd10, 32'd20, 1'b1);
        // A first extent of maximal length pushes the second one to the top of the guest
        // range, so that requests there wrap round to guest sector 0.
        send_load(4'd0, '1, '1);
        send_load(4'd1, 64'd100, 64'd1);
        send_transfer('1, 32'd3, 1'b0);
        send_transfer(64'hFFFF_FFFF_FFFF_FFFE, 32'd5, 1'b1);
        send_transfer(64'd2, '1, 1'b0);            // largest request in a single piece
        send_load(4'd0, rand64(), 64'd6);
        send_load(4'd1, rand64(), 64'd9);

        // Random traffic in three idling regimes, two register settings in each.
        for (ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 13 : (ph == 1) ? 80 : 0;
            for (blk = 0; blk < 2; blk++) begin
                case ($urandom_range(0, 3))
                    0: base = '0;
                    1: base = '1;
                    default: base = rand64();
                endcase
                count = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 31))
                                                    : COUNT_W'($urandom_range(12, 16));
                settle();
                configure(base, count, 1'($urandom_range(0, 1)));
                for (n = 0; n < 38; n++) begin
                    send_random_item();
                end
            end
        end

        settle();
        $display("Sent %0d table loads and %0d transfer requests under %0d register settings.",
                 loads_sent, transfers_sent, settings_used);
        $display("Compared %0d host commands and error results.", o_results_seen);
        if (o_fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: extent_map_request_splitter_core.f
rtl/emrs_pkg.sv
rtl/emrs_front.sv
rtl/emrs_cmd_fifo.sv
rtl/emrs_back.sv
rtl/extent_map_request_splitter_core.sv
rtl/emrs_chk.sv
verif/emrs_tb_codes_pkg.sv
verif/emrs_translation_monitor.sv
verif/tb.sv
